### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the integer to ASCII formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/int_asc_pkg.sv
// Types, codes and the glyph function of the integer to ASCII formatter.
package int_asc_pkg;

  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr;        // clear digit
    logic bit_shift;  // adjust and take one bit from the lower neighbor
    logic dig_shift;  // take the whole digit of the lower neighbor
    logic dec_mode;   // add-3 adjust enabled
  } cell_ctrl_t;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2d;

  function automatic logic [7:0] digit_glyph(input logic [3:0] dig);
    logic [7:0] res;
    if (dig < 4'd10) begin
      res = CharZero + {4'd0, dig};
    end else begin
      res = CharA + {4'd0, dig} - 8'd10;
    end
    return res;
  endfunction

endpackage

### hw/rtl/int_asc_cell.sv
// One digit cell of the conversion chain: shift-and-add-3 or plain nibble shift.
module int_asc_cell (
  input  logic                     clk_i,
  input  int_asc_pkg::cell_ctrl_t  ctrl_i,
  input  logic                     bit_i,
  input  logic [3:0]               digit_i,
  output logic [3:0]               digit_o,
  output logic                     carry_o
);
  import int_asc_pkg::*;

  logic [3:0] dig_q, dig_d;
  logic [3:0] adj;

  always_comb begin
    if (ctrl_i.dec_mode && (dig_q >= 4'd5)) begin
      adj = dig_q + 4'd3;
    end else begin
      adj = dig_q;
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (ctrl_i.clr) begin
      dig_d = 4'd0;
    end else if (ctrl_i.bit_shift) begin
      dig_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dig_shift) begin
      dig_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign digit_o = dig_q;
  assign carry_o = adj[3];

endmodule

### hw/rtl/int_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter: control, digit chain, output register.
// Sequence: the conversion shifts all VALUE_WIDTH bits into the chain, then a leading '-' in
//   signed mode, then every digit position of the chain is read out (10 positions at width 32).
// A new item is taken only in idle, once the last one is done. One bit a cycle enters the chain;
//   one digit a cycle leaves it while the output register can take a character.
// Reset clears control state and the output valid; digit cells hold no reset.
`include "assert_macros.svh"
module int_to_ascii_formatter_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  input  int_asc_pkg::cmd_e       command_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              ascii_char_o,
  output logic                    last_char_o
);
  import int_asc_pkg::*;

  // Decimal digits needed: floor(W * log10(2)) + 1; hex digits: ceil(W / 4).
  localparam int DecDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HexDigits = (VALUE_WIDTH + 3) / 4;
  localparam int NumCells  = (DecDigits > HexDigits) ? DecDigits : HexDigits;
  localparam int CntMax    = (VALUE_WIDTH > NumCells) ? VALUE_WIDTH : NumCells;
  localparam int CntW      = $clog2(CntMax + 1);

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                 dec_q, dec_d;
  logic                 neg_q, neg_d;
  logic                 started_q, started_d;
  logic                 ov_q, ov_d;
  logic [7:0]           char_q, char_d;
  logic                 last_q, last_d;

  logic                 in_xfer;
  logic                 slot_free;
  logic                 emit;
  logic                 is_neg;
  cell_ctrl_t           cell_ctrl;
  logic [3:0]           cell_dig   [NumCells];
  logic                 cell_carry [NumCells];
  logic [3:0]           top_dig;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  // The output register can take a new character when empty or being drained.
  assign slot_free  = !ov_q || !out_stall_i;
  assign top_dig    = cell_dig[NumCells-1];
  // Skip leading zeros, but always print the units digit.
  assign emit       = started_q || (top_dig != 4'd0) || (cnt_q == CntW'(1));
  assign is_neg     = (command_i == CMD_SDEC) && value_i[VALUE_WIDTH-1];

  // Digit chain: cell 0 is the least significant digit.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag_q[VALUE_WIDTH-1];
      assign dig_in = 4'd0;
    end else begin : g_rest
      assign bit_in = cell_carry[i-1];
      assign dig_in = cell_dig[i-1];
    end
    int_asc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (bit_in),
      .digit_i (dig_in),
      .digit_o (cell_dig[i]),
      .carry_o (cell_carry[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (command_i != CMD_NONE)) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_q == CntW'(1)) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && (cnt_q == CntW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d     = cnt_q;
    mag_d     = mag_q;
    dec_d     = dec_q;
    neg_d     = neg_q;
    started_d = started_q;
    char_d    = char_q;
    last_d    = last_q;
    ov_d      = ov_q;
    cell_ctrl = '{clr: 1'b0, bit_shift: 1'b0, dig_shift: 1'b0, dec_mode: dec_q};

    // Drop the held character once the consumer takes it.
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (command_i != CMD_NONE)) begin
          cell_ctrl.clr = 1'b1;
          mag_d     = is_neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
          dec_d     = (command_i != CMD_HEX);
          neg_d     = is_neg;
          started_d = 1'b0;
          cnt_d     = CntW'(VALUE_WIDTH);
        end
      end
      ST_CONV: begin
        // Advance one bit into the chain.
        cell_ctrl.bit_shift = 1'b1;
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        if (cnt_q == CntW'(1)) begin
          cnt_d = CntW'(NumCells);
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          char_d = CharMinus;
          last_d = 1'b0;
          ov_d   = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cell_ctrl.dig_shift = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          if (emit) begin
            started_d = 1'b1;
            char_d    = digit_glyph(top_dig);
            last_d    = (cnt_q == CntW'(1));
            ov_d      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    dec_q  <= dec_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = ov_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

  `ASSERT_NEXT(a_drop_unused, in_xfer && (command_i == CMD_NONE),
               state_q == ST_IDLE, "unused command started work")
  `ASSERT_NEXT(a_start_conv, in_xfer && (command_i != CMD_NONE),
               state_q == ST_CONV, "accepted item did not start conversion")
  `ASSERT_NEXT(a_final_char, (state_q == ST_EMIT) && (cnt_q == CntW'(1)) && slot_free,
               (state_q == ST_IDLE) && out_valid_o && last_char_o,
               "final character not flagged")
  `ASSERT_IMPL(a_mid_text_busy, out_valid_o && !last_char_o,
               state_q != ST_IDLE, "idle with text unfinished")

endmodule
